// ===== rtl/ldpc_soft_erasure_decoder_unit_macros.svh =====
// Assertion macros for the soft erasure decoder.
// Taken in by the top level; the macros expect clk and rst_n in scope.
`ifndef LDPC_SOFT_ERASURE_DECODER_UNIT_MACROS_SVH
`define LDPC_SOFT_ERASURE_DECODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSED_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lsed_pkg.sv =====
// Package for the soft erasure decoder: field widths, codes, sequencer states.
// No dependencies; used by the divider, the top level and the testbench.
`timescale 1ns / 1ps

package lsed_pkg;

    // Stream field widths and packing offsets.
    localparam int ROW_INDEX_W   = 4;
    localparam int ROW_BITS_W    = 32;
    localparam int POSITION_W    = 5;
    localparam int SYMBOL_W      = 2;
    localparam int IN_TDATA_W    = 48;
    localparam int ROW_INDEX_LSB = 0;
    localparam int ROW_BITS_LSB  = 4;
    localparam int POSITION_LSB  = 36;
    localparam int SYMBOL_LSB    = 41;
    localparam int CODEWORD_W    = 32;
    localparam int ITER_W        = 6;
    localparam int OUT_TDATA_W   = 40;

    // Configuration port.
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 6;
    localparam int LEN_CFG_W     = 6;
    localparam int CHK_CFG_W     = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CODE_LENGTH    = 2'd0,
        CFG_CHECK_COUNT    = 2'd1,
        CFG_MAX_ITERATIONS = 2'd2
    } lsed_cfg_index_t;

    // Item kinds and symbol codes.
    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_SYMBOL = 1'b1;
    localparam logic [SYMBOL_W-1:0] SYM_ZERO = 2'd0;
    localparam logic [SYMBOL_W-1:0] SYM_ONE  = 2'd1;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } lsed_div_stat_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_UPD_INIT,
        ST_CHK_ROW,
        ST_CHK_ROWW,
        ST_CHK_J,
        ST_CHK_T,
        ST_CHK_TD,
        ST_CHK_TM,
        ST_CHK_R0,
        ST_CHK_PR,
        ST_CHK_P1,
        ST_CHK_P0,
        ST_FIN_RD,
        ST_FIN_M1,
        ST_FIN_M0,
        ST_FIN_S,
        ST_FIN_DIV,
        ST_ITER,
        ST_SYN_RD,
        ST_SYN_CK,
        ST_DONE
    } lsed_state_t;

endpackage

// ===== rtl/lsed_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lsed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lsed_mul.sv =====
// Shared fixed-point multiplier: rounded half-up product, registered.
// No dependencies.
`timescale 1ns / 1ps

module lsed_mul #(
    parameter int PROB_WIDTH = 16
) (
    input  logic                  clk,
    input  logic [PROB_WIDTH-1:0] a,
    input  logic [PROB_WIDTH-1:0] b,
    output logic [PROB_WIDTH-1:0] product
);

    localparam int FRAC = PROB_WIDTH - 1;
    localparam int PW   = 2 * PROB_WIDTH;
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC - 1);

    logic [PW-1:0] full;

    // Operands never exceed 1.0, so the scaled product fits the width.
    assign full = (PW'(a) * PW'(b)) + HALF;

    always_ff @(posedge clk)
    begin
        product <= full[FRAC +: PROB_WIDTH];
    end

endmodule

// ===== rtl/lsed_div.sv =====
// Bit-serial restoring divider used to normalize posteriors.
// Depends on lsed_pkg for the status struct.
`timescale 1ns / 1ps

module lsed_div #(
    parameter int PROB_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [2*PROB_WIDTH-1:0]     dividend,
    input  logic [PROB_WIDTH:0]         divisor,
    output logic [PROB_WIDTH-1:0]       quotient,
    output lsed_pkg::lsed_div_stat_t    stat
);

    localparam int DW   = 2 * PROB_WIDTH;
    localparam int RW   = PROB_WIDTH + 2;
    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   dv_reg, dv_next;
    logic [DW-1:0]   q_reg, q_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic [RW-1:0]   dsr_reg, dsr_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW-1:0]   trial;
    logic            fits;

    // One quotient bit per cycle, dividend bits shifted in from the top.
    assign trial = {rem_reg[RW-3:0], dv_reg[DW-1]};
    assign fits  = trial >= dsr_reg;

    always_comb
    begin
        dv_next   = dv_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dv_next   = dividend;
            q_next    = '0;
            rem_next  = '0;
            dsr_next  = {1'b0, divisor};
            cnt_next  = CNTW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial - dsr_reg : trial;
            dv_next  = {dv_reg[DW-2:0], 1'b0};
            q_next   = {q_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg  <= dv_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = q_reg[PROB_WIDTH-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/ldpc_soft_erasure_decoder_unit.sv =====
// Top level of the soft erasure decoder; uses lsed_pkg, lsed_ram, lsed_mul, lsed_div, macros.
// Items load while the sequencer is idle. A decode first copies the priors to the posteriors, then
// each update pass sends check messages over every member bit of every row, normalizes each bit's
// posterior (with the serial divider unless the sum is zero) and checks the syndrome unless the
// iteration limit is reached, then finishes. Input is not ready during a decode.
// Reset is asynchronous, active low: sequencer idle, hard bits cleared, registers 32, 16, 26.
`timescale 1ns / 1ps
`include "ldpc_soft_erasure_decoder_unit_macros.svh"

module ldpc_soft_erasure_decoder_unit #(
    parameter int MAX_LENGTH = 32,
    parameter int MAX_CHECKS = 16,
    parameter int PROB_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // row_index[3:0], row_bits[35:4], position[40:36], symbol[42:41], zero fill
    input  logic [lsed_pkg::IN_TDATA_W-1:0]       s_tdata,
    // kind[0]
    input  logic                                  s_tuser,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // codeword[31:0], converged[32], iterations_used[38:33], zero fill
    output logic [lsed_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lsed_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [lsed_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int W     = PROB_WIDTH;
    localparam int LW    = $clog2(MAX_LENGTH);
    localparam int NW    = $clog2(MAX_LENGTH + 1);
    localparam int CW    = (MAX_CHECKS > 1) ? $clog2(MAX_CHECKS) : 1;
    localparam int MW    = $clog2(MAX_CHECKS + 1);
    localparam int RBW   = lsed_pkg::ROW_BITS_W;
    localparam int CDW   = lsed_pkg::CODEWORD_W;
    localparam int ITW   = lsed_pkg::ITER_W;
    localparam logic [W-1:0] PONE  = W'(1) << (W - 1);
    localparam logic [W-1:0] PHALF = W'(1) << (W - 2);

    // Input field unpacking.
    logic [lsed_pkg::ROW_INDEX_W-1:0] in_row_index;
    logic [RBW-1:0]                   in_row_bits;
    logic [lsed_pkg::POSITION_W-1:0]  in_position;
    logic [lsed_pkg::SYMBOL_W-1:0]    in_symbol;
    logic                             in_acc;
    logic                             row_ok;
    logic                             pos_ok;

    assign in_row_index = s_tdata[lsed_pkg::ROW_INDEX_LSB +: lsed_pkg::ROW_INDEX_W];
    assign in_row_bits  = s_tdata[lsed_pkg::ROW_BITS_LSB +: RBW];
    assign in_position  = s_tdata[lsed_pkg::POSITION_LSB +: lsed_pkg::POSITION_W];
    assign in_symbol    = s_tdata[lsed_pkg::SYMBOL_LSB +: lsed_pkg::SYMBOL_W];
    assign in_acc       = s_tvalid && s_tready;
    assign row_ok       = 32'(in_row_index) < MAX_CHECKS;
    assign pos_ok       = 32'(in_position) < MAX_LENGTH;

    // Configuration registers.
    logic [lsed_pkg::LEN_CFG_W-1:0] code_length_reg;
    logic [lsed_pkg::CHK_CFG_W-1:0] check_count_reg;
    logic [ITW-1:0]                 max_iter_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= 6'd32;
            check_count_reg <= 5'd16;
            max_iter_reg    <= 6'd26;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lsed_pkg::CFG_CODE_LENGTH:    code_length_reg <= cfg_data;
                lsed_pkg::CFG_CHECK_COUNT:    check_count_reg <= cfg_data[lsed_pkg::CHK_CFG_W-1:0];
                lsed_pkg::CFG_MAX_ITERATIONS: max_iter_reg    <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    lsed_pkg::lsed_state_t state_reg, state_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [MW-1:0]         m_reg, m_next;
    logic [MAX_LENGTH-1:0] mask_reg, mask_next;
    logic [ITW-1:0]        limit_reg, limit_next;
    logic [ITW-1:0]        iter_reg, iter_next;
    logic                  conv_reg, conv_next;
    logic [NW-1:0]         j_reg, j_next;
    logic [NW-1:0]         t_reg, t_next;
    logic [MW-1:0]         i_reg, i_next;
    logic [MAX_LENGTH-1:0] hard_reg, hard_next;
    logic [MAX_LENGTH-1:0] row_reg, row_next;
    logic [W-1:0]          mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [W-1:0]          r0_reg, r0_next;
    logic [W-1:0]          z_reg, z_next;
    logic [W-1:0]          pr_reg, pr_next;
    logic [W-1:0]          t1_reg, t1_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CDW-1:0]        out_code_reg, out_code_next;
    logic                  out_conv_reg, out_conv_next;
    logic [ITW-1:0]        out_iter_reg, out_iter_next;

    // Memory ports.
    logic [RBW-1:0] row_rd;
    logic [W-1:0]   prior_rd, post_rd, one_rd, zero_rd;
    logic           prior_we, post_we, one_we, zero_we;
    logic [W-1:0]   prior_wd, post_wd, prod_wd;

    // Shared units.
    logic [W-1:0]   mul_a, mul_b, mul_res;
    logic           div_start;
    logic [2*W-1:0] div_dividend;
    logic [W:0]     div_sum;
    logic [W-1:0]   div_quot;
    lsed_pkg::lsed_div_stat_t div_stat;

    // Derived values.
    logic [NW-1:0]         len_eff;
    logic [MW-1:0]         chk_eff;
    logic [MAX_LENGTH-1:0] mask_eff;
    logic [MAX_LENGTH-1:0] row_ext;
    logic [MAX_LENGTH-1:0] hard_masked;
    logic [W:0]            p2;
    logic                  fm_flip;
    logic [W-1:0]          fm;
    logic [W:0]            r0_wide;
    logic [W-1:0]          r1;
    logic                  row_parity;
    logic                  out_load;
    logic [ITW-1:0]        iter_inc;

    assign len_eff = (32'(code_length_reg) > MAX_LENGTH) ? NW'(MAX_LENGTH)
                                                          : NW'(code_length_reg);
    assign chk_eff = (32'(check_count_reg) > MAX_CHECKS) ? MW'(MAX_CHECKS)
                                                          : MW'(check_count_reg);

    always_comb
    begin
        for (int k = 0; k < MAX_LENGTH; k++)
        begin
            mask_eff[k] = k < 32'(len_eff);
        end
    end

    // Fit stored rows to the maximum length and the decision word to the codeword width.
    generate
        if (MAX_LENGTH > RBW)
        begin : g_row_wide
            assign row_ext = {{(MAX_LENGTH - RBW){1'b0}}, row_rd};
        end
        else
        begin : g_row_narrow
            assign row_ext = row_rd[MAX_LENGTH-1:0];
        end
        if (MAX_LENGTH > CDW)
        begin : g_code_narrow
            assign out_code_next = out_load ? hard_masked[CDW-1:0] : out_code_reg;
        end
        else if (MAX_LENGTH == CDW)
        begin : g_code_equal
            assign out_code_next = out_load ? hard_masked : out_code_reg;
        end
        else
        begin : g_code_wide
            assign out_code_next = out_load ? {{(CDW - MAX_LENGTH){1'b0}}, hard_masked}
                                            : out_code_reg;
        end
    endgenerate

    assign hard_masked = hard_reg & mask_reg;
    assign row_parity  = ^(row_ext & hard_reg & mask_reg);

    // Check message: factor (1 - 2p) as sign and magnitude.
    assign p2      = {post_rd, 1'b0};
    assign fm_flip = p2 > {1'b0, PONE};
    assign fm      = fm_flip ? W'(p2 - {1'b0, PONE}) : W'({1'b0, PONE} - p2);
    assign r0_wide = neg_reg ? ({1'b0, PONE} - {1'b0, mag_reg}) >> 1
                             : ({1'b0, PONE} + {1'b0, mag_reg}) >> 1;
    assign r1      = PONE - r0_reg;

    // Posterior normalization operands.
    assign div_sum      = {1'b0, t1_reg} + {1'b0, mul_res};
    assign div_dividend = ((2 * W)'(t1_reg) << (W - 1)) + (2 * W)'(div_sum >> 1);
    assign iter_inc     = iter_reg + ITW'(1);
    assign out_load     = (state_reg == lsed_pkg::ST_DONE) && (!out_valid_reg || m_tready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsed_pkg::ST_IDLE:
                if (in_acc && s_tuser == lsed_pkg::KIND_SYMBOL && pos_ok && s_tlast)
                    state_next = lsed_pkg::ST_START;
            lsed_pkg::ST_START:    state_next = lsed_pkg::ST_COPY_RD;
            lsed_pkg::ST_COPY_RD:
                state_next = (j_reg == n_reg) ? lsed_pkg::ST_UPD_INIT : lsed_pkg::ST_COPY_WR;
            lsed_pkg::ST_COPY_WR:  state_next = lsed_pkg::ST_COPY_RD;
            lsed_pkg::ST_UPD_INIT:
                if (j_reg == n_reg)
                    state_next = lsed_pkg::ST_CHK_ROW;
            lsed_pkg::ST_CHK_ROW:
                state_next = (i_reg == m_reg) ? lsed_pkg::ST_FIN_RD : lsed_pkg::ST_CHK_ROWW;
            lsed_pkg::ST_CHK_ROWW: state_next = lsed_pkg::ST_CHK_J;
            lsed_pkg::ST_CHK_J:
                if (j_reg == n_reg)
                    state_next = lsed_pkg::ST_CHK_ROW;
                else if (row_reg[j_reg[LW-1:0]])
                    state_next = lsed_pkg::ST_CHK_T;
            lsed_pkg::ST_CHK_T:
                if (t_reg == n_reg)
                    state_next = lsed_pkg::ST_CHK_R0;
                else if (t_reg != j_reg && row_reg[t_reg[LW-1:0]])
                    state_next = lsed_pkg::ST_CHK_TD;
            lsed_pkg::ST_CHK_TD:   state_next = lsed_pkg::ST_CHK_TM;
            lsed_pkg::ST_CHK_TM:   state_next = lsed_pkg::ST_CHK_T;
            lsed_pkg::ST_CHK_R0:   state_next = lsed_pkg::ST_CHK_PR;
            lsed_pkg::ST_CHK_PR:   state_next = lsed_pkg::ST_CHK_P1;
            lsed_pkg::ST_CHK_P1:   state_next = lsed_pkg::ST_CHK_P0;
            lsed_pkg::ST_CHK_P0:   state_next = lsed_pkg::ST_CHK_J;
            lsed_pkg::ST_FIN_RD:
                state_next = (j_reg == n_reg) ? lsed_pkg::ST_ITER : lsed_pkg::ST_FIN_M1;
            lsed_pkg::ST_FIN_M1:   state_next = lsed_pkg::ST_FIN_M0;
            lsed_pkg::ST_FIN_M0:   state_next = lsed_pkg::ST_FIN_S;
            lsed_pkg::ST_FIN_S:
                state_next = (div_sum == '0) ? lsed_pkg::ST_FIN_RD : lsed_pkg::ST_FIN_DIV;
            lsed_pkg::ST_FIN_DIV:
                if (div_stat.done)
                    state_next = lsed_pkg::ST_FIN_RD;
            lsed_pkg::ST_ITER:
                state_next = (iter_inc >= limit_reg) ? lsed_pkg::ST_DONE : lsed_pkg::ST_SYN_RD;
            lsed_pkg::ST_SYN_RD:
                state_next = (i_reg == m_reg) ? lsed_pkg::ST_DONE : lsed_pkg::ST_SYN_CK;
            lsed_pkg::ST_SYN_CK:
                state_next = row_parity ? lsed_pkg::ST_UPD_INIT : lsed_pkg::ST_SYN_RD;
            lsed_pkg::ST_DONE:
                if (out_load)
                    state_next = lsed_pkg::ST_IDLE;
            default:               state_next = lsed_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: input ready, memory writes, multiplier operands, divider start.
    always_comb
    begin
        s_tready  = state_reg == lsed_pkg::ST_IDLE;
        prior_we  = 1'b0;
        post_we   = 1'b0;
        one_we    = 1'b0;
        zero_we   = 1'b0;
        post_wd   = prior_rd;
        prod_wd   = mul_res;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        case (in_symbol)
            lsed_pkg::SYM_ZERO: prior_wd = '0;
            lsed_pkg::SYM_ONE:  prior_wd = PONE;
            default:            prior_wd = PHALF;
        endcase
        case (state_reg)
            lsed_pkg::ST_IDLE:
                prior_we = in_acc && s_tuser == lsed_pkg::KIND_SYMBOL && pos_ok;
            lsed_pkg::ST_COPY_WR:
                post_we = 1'b1;
            lsed_pkg::ST_UPD_INIT:
            begin
                one_we  = j_reg != n_reg;
                zero_we = j_reg != n_reg;
                prod_wd = PONE;
            end
            lsed_pkg::ST_CHK_TD:
            begin
                mul_a = mag_reg;
                mul_b = fm;
            end
            lsed_pkg::ST_CHK_PR:
            begin
                mul_a = one_rd;
                mul_b = r1;
            end
            lsed_pkg::ST_CHK_P1:
            begin
                one_we = 1'b1;
                mul_a  = z_reg;
                mul_b  = r0_reg;
            end
            lsed_pkg::ST_CHK_P0:
                zero_we = 1'b1;
            lsed_pkg::ST_FIN_M1:
            begin
                mul_a = one_rd;
                mul_b = prior_rd;
            end
            lsed_pkg::ST_FIN_M0:
            begin
                mul_a = z_reg;
                mul_b = PONE - pr_reg;
            end
            lsed_pkg::ST_FIN_S:
            begin
                post_we   = div_sum == '0;
                post_wd   = PHALF;
                div_start = div_sum != '0;
            end
            lsed_pkg::ST_FIN_DIV:
            begin
                post_we = div_stat.done;
                post_wd = div_quot;
            end
            default:
                ;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        n_next     = n_reg;
        m_next     = m_reg;
        mask_next  = mask_reg;
        limit_next = limit_reg;
        iter_next  = iter_reg;
        conv_next  = conv_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        i_next     = i_reg;
        hard_next  = hard_reg;
        row_next   = row_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        r0_next    = r0_reg;
        z_next     = z_reg;
        pr_next    = pr_reg;
        t1_next    = t1_reg;
        case (state_reg)
            lsed_pkg::ST_START:
            begin
                n_next     = len_eff;
                m_next     = chk_eff;
                mask_next  = mask_eff;
                limit_next = (max_iter_reg == '0) ? ITW'(1) : max_iter_reg;
                iter_next  = '0;
                conv_next  = 1'b0;
                j_next     = '0;
            end
            lsed_pkg::ST_COPY_RD:
                if (j_reg == n_reg)
                    j_next = '0;
            lsed_pkg::ST_COPY_WR:
                j_next = j_reg + NW'(1);
            lsed_pkg::ST_UPD_INIT:
                if (j_reg == n_reg)
                    i_next = '0;
                else
                    j_next = j_reg + NW'(1);
            lsed_pkg::ST_CHK_ROW:
                if (i_reg == m_reg)
                begin
                    j_next    = '0;
                    hard_next = '0;
                end
            lsed_pkg::ST_CHK_ROWW:
            begin
                row_next = row_ext & mask_reg;
                j_next   = '0;
            end
            lsed_pkg::ST_CHK_J:
                if (j_reg == n_reg)
                    i_next = i_reg + MW'(1);
                else if (row_reg[j_reg[LW-1:0]])
                begin
                    t_next   = '0;
                    mag_next = PONE;
                    neg_next = 1'b0;
                end
                else
                    j_next = j_reg + NW'(1);
            lsed_pkg::ST_CHK_T:
                if (t_reg != n_reg && !(t_reg != j_reg && row_reg[t_reg[LW-1:0]]))
                    t_next = t_reg + NW'(1);
            lsed_pkg::ST_CHK_TD:
                neg_next = neg_reg ^ fm_flip;
            lsed_pkg::ST_CHK_TM:
            begin
                mag_next = mul_res;
                if (mul_res == '0)
                    neg_next = 1'b0;
                t_next = t_reg + NW'(1);
            end
            lsed_pkg::ST_CHK_R0:
                r0_next = W'(r0_wide);
            lsed_pkg::ST_CHK_PR:
                z_next = zero_rd;
            lsed_pkg::ST_CHK_P0:
                j_next = j_reg + NW'(1);
            lsed_pkg::ST_FIN_M1:
            begin
                z_next  = zero_rd;
                pr_next = prior_rd;
            end
            lsed_pkg::ST_FIN_M0:
                t1_next = mul_res;
            lsed_pkg::ST_FIN_S:
            begin
                hard_next[j_reg[LW-1:0]] = t1_reg > mul_res;
                if (div_sum == '0)
                    j_next = j_reg + NW'(1);
            end
            lsed_pkg::ST_FIN_DIV:
                if (div_stat.done)
                    j_next = j_reg + NW'(1);
            lsed_pkg::ST_ITER:
            begin
                iter_next = iter_inc;
                i_next    = '0;
            end
            lsed_pkg::ST_SYN_RD:
                if (i_reg == m_reg)
                    conv_next = 1'b1;
            lsed_pkg::ST_SYN_CK:
                if (row_parity)
                    j_next = '0;
                else
                    i_next = i_reg + MW'(1);
            default:
                ;
        endcase
    end

    // Output register: holds one finished result while loads go on.
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_conv_next  = out_conv_reg;
        out_iter_next  = out_iter_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_conv_next  = conv_reg;
            out_iter_next  = iter_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsed_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            hard_reg      <= '0;
            iter_reg      <= '0;
            limit_reg     <= ITW'(1);
            conv_reg      <= 1'b0;
            n_reg         <= '0;
            m_reg         <= '0;
            mask_reg      <= '0;
            j_reg         <= '0;
            t_reg         <= '0;
            i_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hard_reg      <= hard_next;
            iter_reg      <= iter_next;
            limit_reg     <= limit_next;
            conv_reg      <= conv_next;
            n_reg         <= n_next;
            m_reg         <= m_next;
            mask_reg      <= mask_next;
            j_reg         <= j_next;
            t_reg         <= t_next;
            i_reg         <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        r0_reg       <= r0_next;
        z_reg        <= z_next;
        pr_reg       <= pr_next;
        t1_reg       <= t1_next;
        out_code_reg <= out_code_next;
        out_conv_reg <= out_conv_next;
        out_iter_reg <= out_iter_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_iter_reg, out_conv_reg, out_code_reg};

    // State memories.
    lsed_ram #(.WIDTH(RBW), .DEPTH(MAX_CHECKS)) u_rows (
        .clk   (clk),
        .we    (in_acc && s_tuser == lsed_pkg::KIND_ROW && row_ok),
        .waddr (CW'(in_row_index)),
        .wdata (in_row_bits),
        .raddr (i_reg[CW-1:0]),
        .rdata (row_rd)
    );

    lsed_ram #(.WIDTH(W), .DEPTH(MAX_LENGTH)) u_prior (
        .clk   (clk),
        .we    (prior_we),
        .waddr (LW'(in_position)),
        .wdata (prior_wd),
        .raddr (j_reg[LW-1:0]),
        .rdata (prior_rd)
    );

    lsed_ram #(.WIDTH(W), .DEPTH(MAX_LENGTH)) u_post (
        .clk   (clk),
        .we    (post_we),
        .waddr (j_reg[LW-1:0]),
        .wdata (post_wd),
        .raddr (t_reg[LW-1:0]),
        .rdata (post_rd)
    );

    lsed_ram #(.WIDTH(W), .DEPTH(MAX_LENGTH)) u_one (
        .clk   (clk),
        .we    (one_we),
        .waddr (j_reg[LW-1:0]),
        .wdata (prod_wd),
        .raddr (j_reg[LW-1:0]),
        .rdata (one_rd)
    );

    lsed_ram #(.WIDTH(W), .DEPTH(MAX_LENGTH)) u_zero (
        .clk   (clk),
        .we    (zero_we),
        .waddr (j_reg[LW-1:0]),
        .wdata (prod_wd),
        .raddr (j_reg[LW-1:0]),
        .rdata (zero_rd)
    );

    // Shared arithmetic units.
    lsed_mul #(.PROB_WIDTH(W)) u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_res)
    );

    lsed_div #(.PROB_WIDTH(W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_sum),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // Checks on the sequencer.
    `LSED_ASSERT_SAME(a_iter_bound, state_reg != lsed_pkg::ST_IDLE, iter_reg <= limit_reg, "iteration count passed its limit")
    `LSED_ASSERT_SAME(a_div_free, div_start, !div_stat.busy, "divider started while busy")
    `LSED_ASSERT_NEXT(a_done_drains, state_reg == lsed_pkg::ST_DONE && m_tready, state_reg == lsed_pkg::ST_IDLE && m_tvalid, "finished result not handed to the output register")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the soft erasure decoder unit.
// Depends on lsed_pkg and ldpc_soft_erasure_decoder_unit; drives both streams and config.
`timescale 1ns / 1ps

module testbench;

    localparam int LEN_MAX     = 32;
    localparam int CHK_MAX     = 16;
    localparam int FRAC_BITS   = 15;
    localparam longint unsigned P_ONE  = 64'd1 << FRAC_BITS;
    localparam longint unsigned P_HALF = P_ONE >> 1;
    localparam int IDLE_LIMIT  = 600000;
    localparam logic [lsed_pkg::SYMBOL_W-1:0] SYM_ERASED = 2'd2;
    localparam logic [lsed_pkg::SYMBOL_W-1:0] SYM_THREE  = 2'd3;

    typedef struct {
        logic [31:0] codeword;
        logic        converged;
        logic [5:0]  iterations;
    } decoded_word_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [lsed_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             s_tuser = 1'b0;
    logic                             s_tlast = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [lsed_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [lsed_pkg::CFG_INDEX_W-1:0] cfg_index = lsed_pkg::CFG_CODE_LENGTH;
    logic [lsed_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow of the decoder state used for prediction.
    logic [31:0]       rows_q [CHK_MAX];
    longint unsigned   prior_q [LEN_MAX];
    longint unsigned   post_q [LEN_MAX];
    logic [CHK_MAX-1:0] row_known = '0;
    logic [LEN_MAX-1:0] sym_known = '0;
    int len_cfg  = 32;
    int chk_cfg  = 16;
    int iter_cfg = 26;

    decoded_word_t pending_words[$];
    int error_count   = 0;
    int items_sent    = 0;
    int words_checked = 0;
    int words_early   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    ldpc_soft_erasure_decoder_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b + P_HALF) >> FRAC_BITS;
    endfunction

    function automatic bit syndrome_clear(int m, logic [31:0] mask, logic [31:0] hard);
        for (int i = 0; i < m; i++)
            if (^(rows_q[i] & hard & mask))
                return 1'b0;
        return 1'b1;
    endfunction

    // Belief propagation over the shadow state, one full decode.
    function automatic decoded_word_t predict_decode();
        longint unsigned one_p [LEN_MAX];
        longint unsigned zero_p [LEN_MAX];
        longint unsigned mag, r0, r1, p2, fm, t1, t0, s;
        logic [31:0] row, mask, hard;
        bit neg, conv;
        int n, m, limit, iter;
        decoded_word_t w;
        n = (len_cfg > LEN_MAX) ? LEN_MAX : len_cfg;
        m = (chk_cfg > CHK_MAX) ? CHK_MAX : chk_cfg;
        limit = (iter_cfg == 0) ? 1 : iter_cfg;
        mask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        for (int j = 0; j < LEN_MAX; j++)
            post_q[j] = prior_q[j];
        iter = 0;
        conv = 1'b0;
        hard = '0;
        while (iter < limit)
        begin
            for (int j = 0; j < n; j++)
            begin
                one_p[j] = P_ONE;
                zero_p[j] = P_ONE;
            end
            // Check-to-bit messages.
            for (int i = 0; i < m; i++)
            begin
                row = rows_q[i] & mask;
                for (int j = 0; j < n; j++)
                begin
                    if (!row[j])
                        continue;
                    mag = P_ONE;
                    neg = 1'b0;
                    for (int t = 0; t < n; t++)
                    begin
                        if (t == j || !row[t])
                            continue;
                        p2 = 2 * post_q[t];
                        if (p2 > P_ONE)
                        begin
                            fm = p2 - P_ONE;
                            neg = !neg;
                        end
                        else
                            fm = P_ONE - p2;
                        mag = qmul(mag, fm);
                        if (mag == 0)
                            neg = 1'b0;
                    end
                    r0 = neg ? (P_ONE - mag) >> 1 : (P_ONE + mag) >> 1;
                    r1 = P_ONE - r0;
                    one_p[j] = qmul(one_p[j], r1);
                    zero_p[j] = qmul(zero_p[j], r0);
                end
            end
            // Posteriors and hard decisions.
            hard = '0;
            for (int j = 0; j < n; j++)
            begin
                t1 = qmul(one_p[j], prior_q[j]);
                t0 = qmul(zero_p[j], P_ONE - prior_q[j]);
                s = t1 + t0;
                post_q[j] = (s == 0) ? P_HALF : (t1 * P_ONE + (s >> 1)) / s;
                if (t1 > t0)
                    hard[j] = 1'b1;
            end
            iter++;
            if (iter < limit && syndrome_clear(m, mask, hard))
            begin
                conv = 1'b1;
                break;
            end
        end
        w.codeword = hard & mask;
        w.converged = conv;
        w.iterations = iter[5:0];
        return w;
    endfunction

    // Updates the shadow state for one accepted item.
    task automatic record_item(logic kind, logic [3:0] idx, logic [31:0] bits,
                               logic [4:0] pos, logic [1:0] sym, logic last);
        decoded_word_t expected_word;
        if (kind == lsed_pkg::KIND_ROW)
        begin
            rows_q[idx] = bits;
            row_known[idx] = 1'b1;
        end
        else
        begin
            prior_q[pos] = (sym == lsed_pkg::SYM_ZERO) ? 0
                           : ((sym == lsed_pkg::SYM_ONE) ? P_ONE : P_HALF);
            sym_known[pos] = 1'b1;
            if (last)
            begin
                expected_word = predict_decode();
                pending_words.insert(pending_words.size(), expected_word);
            end
        end
    endtask

    // Sends one item, with random idle cycles ahead of it.
    task automatic send_item(logic kind, logic [3:0] idx, logic [31:0] bits,
                             logic [4:0] pos, logic [1:0] sym, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {5'b0, sym, pos, bits, idx};
        do
            @(posedge clk);
        while (!s_tready);
        record_item(kind, idx, bits, pos, sym, last);
        items_sent++;
    endtask

    task automatic send_row(int idx, logic [31:0] bits, logic last = 1'b0);
        send_item(lsed_pkg::KIND_ROW, idx[3:0], bits, 5'($urandom), 2'($urandom), last);
    endtask

    task automatic send_symbol(int pos, logic [1:0] sym, logic last);
        send_item(lsed_pkg::KIND_SYMBOL, 4'($urandom), $urandom, pos[4:0], sym, last);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every decoded word has come out and the block is idle.
    task automatic wait_drained();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(lsed_pkg::lsed_cfg_index_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[lsed_pkg::CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lsed_pkg::CFG_CODE_LENGTH:    len_cfg  = value & 6'h3F;
            lsed_pkg::CFG_CHECK_COUNT:    chk_cfg  = value & 5'h1F;
            lsed_pkg::CFG_MAX_ITERATIONS: iter_cfg = value & 6'h3F;
            default: ;
        endcase
    endtask

    task automatic configure(int n, int m, int iters);
        stop_sending();
        wait_drained();
        write_reg(lsed_pkg::CFG_CODE_LENGTH, n);
        write_reg(lsed_pkg::CFG_CHECK_COUNT, m);
        write_reg(lsed_pkg::CFG_MAX_ITERATIONS, iters);
        @(posedge clk);
    endtask

    // A valid codeword under systematic rows, sent with erasures and a few flips.
    task automatic send_codeword_frame(int n, int m);
        logic [31:0] rows [CHK_MAX];
        logic [31:0] word, mask;
        logic [1:0] sym;
        int off, pos;
        mask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        for (int i = 0; i < m; i++)
        begin
            rows[i] = $urandom;
            for (int k = 0; k < m; k++)
                rows[i][k] = (k == i);
            send_row(i, rows[i]);
        end
        word = $urandom & mask;
        for (int k = 0; k < m; k++)
            word[k] = 1'b0;
        for (int i = 0; i < m; i++)
            word[i] = ^(rows[i] & word & mask);
        off = $urandom_range(n - 1);
        for (int k = 0; k < n; k++)
        begin
            pos = (k + off) % n;
            if ($urandom_range(99) < 30)
                sym = $urandom_range(1) ? SYM_ERASED : SYM_THREE;
            else if ($urandom_range(99) < 6)
                sym = word[pos] ? lsed_pkg::SYM_ZERO : lsed_pkg::SYM_ONE;
            else
                sym = word[pos] ? lsed_pkg::SYM_ONE : lsed_pkg::SYM_ZERO;
            send_symbol(pos, sym, k == n - 1);
        end
    endtask

    // Random items; a decode is asked only when every entry in use is written.
    task automatic send_noise_frame(int n, int m);
        logic [LEN_MAX-1:0] need_sym;
        logic [CHK_MAX-1:0] need_row;
        int count;
        logic last;
        need_sym = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
        need_row = (m >= 16) ? '1 : ((16'd1 << m) - 16'd1);
        count = $urandom_range(8, 3);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(2) == 0)
                send_row($urandom_range(15), $urandom, 1'($urandom));
            else
            begin
                last = (k == count - 1) && ((sym_known & need_sym) == need_sym)
                       && ((row_known & need_row) == need_row);
                send_symbol($urandom_range(31), 2'($urandom), last);
            end
        end
    endtask

    task automatic random_config();
        int n, m;
        n = $urandom_range(12, 2);
        m = $urandom_range((n - 1 < 6) ? n - 1 : 6, 1);
        configure(n, m, ($urandom_range(9) == 0) ? 63 : $urandom_range(10, 1));
    endtask

    // Directed cases: extra row bits, last mark on a row, erasures, symbol three.
    task automatic test_directed_small();
        configure(4, 2, 63);
        send_row(0, 32'hFFFF_FFF3);
        send_row(1, 32'h8000_000E, 1'b1);
        send_symbol(0, lsed_pkg::SYM_ONE, 1'b0);
        send_symbol(1, SYM_ERASED, 1'b0);
        send_symbol(2, SYM_THREE, 1'b0);
        send_symbol(3, lsed_pkg::SYM_ZERO, 1'b1);
        send_row(1, 32'h0000_0000);
        for (int k = 0; k < 4; k++)
            send_symbol(k, SYM_ERASED, k == 3);
        configure(3, 1, 1);
        send_row(0, 32'h0000_0007);
        send_symbol(0, lsed_pkg::SYM_ONE, 1'b0);
        send_symbol(1, lsed_pkg::SYM_ONE, 1'b0);
        send_symbol(2, lsed_pkg::SYM_ZERO, 1'b1);
    endtask

    // Zero length, zero checks and zero iterations.
    task automatic test_zero_settings();
        configure(0, 0, 0);
        send_symbol(0, lsed_pkg::SYM_ONE, 1'b1);
        send_symbol(5, SYM_ERASED, 1'b1);
    endtask

    // Oversized length and check count saturate to the full code.
    task automatic test_saturation();
        logic [31:0] bits;
        configure(63, 31, 1);
        for (int i = 0; i < CHK_MAX; i++)
        begin
            bits = (i == CHK_MAX - 1) ? 32'hFFFF_FFFF
                   : ((32'd1 << $urandom_range(31)) | (32'd1 << $urandom_range(31))
                      | (32'd1 << $urandom_range(31)));
            send_row(i, bits);
        end
        for (int k = 0; k < LEN_MAX; k++)
            send_symbol(k, 2'($urandom_range(2)), k == LEN_MAX - 1);
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        int stop_at, frames;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + count;
        frames = 0;
        random_config();
        while (items_sent < stop_at)
        begin
            if (frames % 8 == 7)
                random_config();
            if ($urandom_range(99) < 80)
                send_codeword_frame(len_cfg, chk_cfg);
            else
                send_noise_frame(len_cfg, chk_cfg);
            frames++;
        end
    endtask

    // Receiver holds off for a long stretch while frames keep coming.
    task automatic test_output_backpressure();
        configure(6, 3, 8);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 3000;
        for (int f = 0; f < 6; f++)
            send_codeword_frame(6, 3);
    endtask

    // Result checker and receiver stalls.
    always @(posedge clk)
    begin
        decoded_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("decoded word with none expected: %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_words.pop_front();
                    words_checked++;
                    if (m_tdata[32])
                        words_early++;
                    if (m_tdata[31:0] !== want.codeword)
                    begin
                        $error("codeword: expected %h, got %h", want.codeword, m_tdata[31:0]);
                        error_count++;
                    end
                    if (m_tdata[32] !== want.converged)
                    begin
                        $error("converged: expected %0d, got %0d", want.converged, m_tdata[32]);
                        error_count++;
                    end
                    if (m_tdata[38:33] !== want.iterations)
                    begin
                        $error("iterations_used: expected %0d, got %0d",
                               want.iterations, m_tdata[38:33]);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("ldpc_soft_erasure_decoder_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < CHK_MAX; i++)
            rows_q[i] = '0;
        for (int j = 0; j < LEN_MAX; j++)
        begin
            prior_q[j] = 0;
            post_q[j] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_small();
        test_zero_settings();
        test_saturation();
        test_random_phase(0, 0, 400);
        test_random_phase(54, 0, 400);
        test_random_phase(0, 54, 400);
        test_random_phase(26, 26, 400);
        test_output_backpressure();

        stop_sending();
        wait_drained();
        $display("Sent %0d items and checked %0d decoded words, %0d stopped early,",
                 items_sent, words_checked, words_early);
        $display("across small, zero, saturated and random code settings with stalls.");
        if (error_count == 0 && pending_words.size() == 0)
            $display("ldpc_soft_erasure_decoder_unit verification clean");
        else
            $display("ldpc_soft_erasure_decoder_unit verification failed");
        $finish;
    end

endmodule
